@@ rtl/kqt_pkg.sv @@
// Shared constants, codes and types of the keyed quantity table.
`default_nettype none
package kqt_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int QTY_W    = 32;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

   localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);

   typedef struct packed {
      logic                     cmp_en;
      logic signed [KEY_W-1:0]  cmp_key;
      logic                     shift_en;
      logic                     ins_en;
      logic signed [KEY_W-1:0]  ins_key;
      logic signed [QTY_W-1:0]  ins_qty;
      logic                     upd_en;
      logic signed [QTY_W-1:0]  upd_qty;
      logic [CNT_W-1:0]         count;
   } kqt_cell_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/kqt_cell.sv @@
// One table entry: key and quantity storage, key compare and neighbor shift.
`default_nettype none
module kqt_cell
   import kqt_pkg::*;
(
   input  wire logic                    clock,
   input  wire kqt_cell_ctrl_type       ctrl,
   input  wire logic [IDX_W-1:0]        cell_index,
   input  wire logic signed [KEY_W-1:0] next_key,
   input  wire logic signed [QTY_W-1:0] next_qty,
   input  wire logic signed [KEY_W-1:0] head_key,
   input  wire logic signed [QTY_W-1:0] head_qty,
   output logic signed [KEY_W-1:0]      key_ff,
   output logic signed [QTY_W-1:0]      qty_ff,
   output logic                         hit_ff
);

   logic             occupied;
   logic             wrap;
   logic [CNT_W-1:0] index_ext;

   assign index_ext = {1'b0, cell_index};
   assign occupied  = index_ext < ctrl.count;
   assign wrap      = (index_ext + CNT_W'(1)) == ctrl.count;

   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         hit_ff <= occupied && (key_ff == ctrl.cmp_key);
      end
      if (ctrl.shift_en && occupied) begin
         key_ff <= wrap ? head_key : next_key;
         qty_ff <= wrap ? head_qty : next_qty;
      end else if (ctrl.ins_en && (index_ext == ctrl.count)) begin
         key_ff <= ctrl.ins_key;
         qty_ff <= ctrl.ins_qty;
      end else if (ctrl.upd_en && hit_ff) begin
         qty_ff <= ctrl.upd_qty;
      end
   end

endmodule
`default_nettype wire

@@ rtl/keyed_quantity_table.sv @@
// Top level of the keyed quantity table: request control, entry chain and result register.
//
//   channel | direction | ports (by prefix)
//   req     | in        | valid stall func part_key quantity
//   rsp     | out       | valid stall status found_key found_quantity entry_index last
//
// Insert, search and update first compare the key in every cell on the request
// transfer; in ST_RESOLVE the hits are then reduced and the result loaded.
// Dump of a non-empty table goes on to ST_DUMP, one entry per result; entries rotate down
// the cell chain and leave through cell 0. Synchronous reset empties the table at once.
// A stalled result holds its register; the next request is taken, and its result waits.
`default_nettype none
module keyed_quantity_table
   import kqt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [FUNC_W-1:0]          req_func,
   input  wire logic signed [KEY_W-1:0]    req_part_key,
   input  wire logic signed [QTY_W-1:0]    req_quantity,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic signed [KEY_W-1:0]         rsp_found_key,
   output logic signed [QTY_W-1:0]         rsp_found_quantity,
   output logic [IDX_W-1:0]                rsp_entry_index,
   output logic                            rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESOLVE,
      ST_DUMP
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        dump_idx_ff, dump_idx_in;
   logic [FUNC_W-1:0]       func_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic signed [QTY_W-1:0] qty_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic signed [QTY_W-1:0] rsp_qty_ff, rsp_qty_in;
   logic [IDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_xfer;
   logic                    out_free;
   kqt_cell_ctrl_type       ctrl;

   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic signed [QTY_W-1:0] cell_qty [CAPACITY];
   logic                    cell_hit [CAPACITY];

   logic                    hit_any;
   logic signed [KEY_W-1:0] hit_key;
   logic signed [QTY_W-1:0] hit_qty;
   logic [IDX_W-1:0]        hit_idx;
   logic signed [QTY_W:0]   sum;
   logic signed [QTY_W-1:0] sat_qty;
   logic                    dump_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_key      = rsp_key_ff;
   assign rsp_found_quantity = rsp_qty_ff;
   assign rsp_entry_index    = rsp_idx_ff;
   assign rsp_last           = rsp_last_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] nkey;
      logic signed [QTY_W-1:0] nqty;
      if (i == CAPACITY - 1) begin : g_tail
         assign nkey = cell_key[0];
         assign nqty = cell_qty[0];
      end else begin : g_body
         assign nkey = cell_key[i+1];
         assign nqty = cell_qty[i+1];
      end
      kqt_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .next_key   (nkey),
         .next_qty   (nqty),
         .head_key   (cell_key[0]),
         .head_qty   (cell_qty[0]),
         .key_ff     (cell_key[i]),
         .qty_ff     (cell_qty[i]),
         .hit_ff     (cell_hit[i])
      );
   end

   always_comb begin
      hit_any = 1'b0;
      hit_key = '0;
      hit_qty = '0;
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_hit[i]) begin
            hit_any = 1'b1;
            hit_key = hit_key | cell_key[i];
            hit_qty = hit_qty | cell_qty[i];
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   always_comb begin
      sum = {hit_qty[QTY_W-1], hit_qty} + {qty_ff[QTY_W-1], qty_ff};
      if (sum[QTY_W] != sum[QTY_W-1]) begin
         sat_qty = sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
      end else begin
         sat_qty = sum[QTY_W-1:0];
      end
   end

   assign dump_last = ({1'b0, dump_idx_ff} + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;

      ctrl          = '0;
      ctrl.cmp_en   = req_xfer;
      ctrl.cmp_key  = req_part_key;
      ctrl.ins_key  = key_ff;
      ctrl.ins_qty  = qty_ff;
      ctrl.upd_qty  = sat_qty;
      ctrl.count    = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_key_in    = '0;
               rsp_qty_in    = '0;
               rsp_idx_in    = '0;
               case (func_ff)
                  FUNC_INSERT: begin
                     if (count_ff == CAPACITY_CNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (hit_any) begin
                        rsp_status_in = STATUS_PRESENT;
                        rsp_key_in    = hit_key;
                        rsp_qty_in    = hit_qty;
                        rsp_idx_in    = hit_idx;
                     end else begin
                        ctrl.ins_en = 1'b1;
                        rsp_key_in  = key_ff;
                        rsp_qty_in  = qty_ff;
                        rsp_idx_in  = count_ff[IDX_W-1:0];
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_SEARCH, FUNC_UPDATE: begin
                     if (!hit_any) begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end else begin
                        rsp_key_in = hit_key;
                        rsp_idx_in = hit_idx;
                        if (func_ff == FUNC_UPDATE) begin
                           ctrl.upd_en = 1'b1;
                           rsp_qty_in  = sat_qty;
                        end else begin
                           rsp_qty_in  = hit_qty;
                        end
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_DUMP;
                        dump_idx_in  = '0;
                     end
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               ctrl.shift_en = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_key_in    = cell_key[0];
               rsp_qty_in    = cell_qty[0];
               rsp_idx_in    = dump_idx_ff;
               rsp_last_in   = dump_last;
               dump_idx_in   = dump_idx_ff + IDX_W'(1);
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         func_ff <= req_func;
         key_ff  <= req_part_key;
         qty_ff  <= req_quantity;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
`default_nettype wire
